FILE: rtl/dpps_pkg.sv
// ----------------------------------------------------------------------------
// dpps_pkg: shared types and constants of the priority scheduler
// Record layout, outcome codes, queue sizing and the front/back queue entry.
// ----------------------------------------------------------------------------
package dpps_pkg;

  localparam int QueueDepth = 16;
  localparam int SlotW      = $clog2(QueueDepth);
  localparam int CountW     = $clog2(QueueDepth + 1);
  localparam int OutCountW  = 5;
  localparam int FifoDepth  = 2;
  localparam int FifoPtrW   = $clog2(FifoDepth);

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_RUN  = 1'b1;

  typedef enum logic [2:0] {
    OUT_REQUEUED = 3'd0,
    OUT_FINISHED = 3'd1,
    OUT_OVERRUN  = 3'd2,
    OUT_LOADED   = 3'd3,
    OUT_FULL     = 3'd4,
    OUT_EMPTY    = 3'd5
  } outcome_t;

  typedef struct packed {
    logic [7:0]         name;
    logic signed [7:0]  pri;
    logic [15:0]        arrival;
    logic [15:0]        required;
    logic [15:0]        used;
  } rec_t;

  typedef struct packed {
    logic kind;
    rec_t rec;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // a must be served before b
  function automatic logic beats(input rec_t a, input rec_t b, input logic later_first);
    logic r;
    if (a.pri != b.pri) r = (a.pri > b.pri);
    else if (later_first) r = (a.arrival > b.arrival);
    else r = (a.arrival < b.arrival);
    return r;
  endfunction

endpackage

FILE: rtl/dpps_front.sv
// ----------------------------------------------------------------------------
// dpps_front: command intake
// Accepts items, classifies them as load or run and pushes them into a
// two-entry queue that feeds the execution side.
// ----------------------------------------------------------------------------
module dpps_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_kind,
  input  logic [7:0]          in_proc_name,
  input  logic signed [7:0]   in_proc_priority,
  input  logic [15:0]         in_arrival_time,
  input  logic [15:0]         in_required_time,
  input  logic [15:0]         in_used_time,
  output logic                cmd_valid,
  output dpps_pkg::cmd_t      cmd,
  input  logic                cmd_take
);

  dpps_pkg::cmd_t                   mem_r [dpps_pkg::FifoDepth];
  logic [dpps_pkg::FifoPtrW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [dpps_pkg::FifoPtrW:0]      cnt_r, cnt_nxt;
  logic                             push, pop;
  dpps_pkg::cmd_t                   in_cmd;

  always_comb begin
    in_cmd.kind         = in_kind;
    in_cmd.rec.name     = in_proc_name;
    in_cmd.rec.pri      = in_proc_priority;
    in_cmd.rec.arrival  = in_arrival_time;
    in_cmd.rec.required = in_required_time;
    // a run's record fields are packed too, but the back end ignores them
    in_cmd.rec.used     = in_used_time;
  end

  assign in_stall  = (cnt_r == (dpps_pkg::FifoPtrW+1)'(dpps_pkg::FifoDepth));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != '0);
  assign pop       = cmd_valid && cmd_take;
  assign cmd       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + (dpps_pkg::FifoPtrW)'(push);
    rd_ptr_nxt = rd_ptr_r + (dpps_pkg::FifoPtrW)'(pop);
    cnt_nxt    = cnt_r + (dpps_pkg::FifoPtrW+1)'(push) - (dpps_pkg::FifoPtrW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

FILE: rtl/dpps_back.sv
// ----------------------------------------------------------------------------
// dpps_back: ready queue and slice execution
// Holds the records, scans them one slot a cycle for the winner or the first
// free slot, applies the step and presents the result in an output register.
// ----------------------------------------------------------------------------
module dpps_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                tie_later_first,
  input  logic                cmd_valid,
  input  dpps_pkg::cmd_t      cmd,
  output logic                cmd_take,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          out_outcome,
  output logic [7:0]          out_run_name,
  output logic signed [7:0]   out_run_priority,
  output logic [15:0]         out_run_arrival,
  output logic [15:0]         out_run_required,
  output logic [15:0]         out_run_used,
  output logic [4:0]          out_ready_count
);

  localparam int D = dpps_pkg::QueueDepth;
  localparam int SW = dpps_pkg::SlotW;
  localparam int CW = dpps_pkg::CountW;
  localparam int OutCountW = dpps_pkg::OutCountW;

  dpps_pkg::rec_t         recs_r [D];
  logic [D-1:0]           vld_r;
  logic [CW-1:0]          count_r;
  dpps_pkg::state_t       state_r, state_nxt;
  logic [SW:0]            idx_r;
  logic                   found_r;
  logic [SW-1:0]          best_r;
  dpps_pkg::rec_t         best_rec_r;
  dpps_pkg::cmd_t         cur_r;
  logic                   ovalid_r;
  dpps_pkg::rec_t         rd_rec;
  logic [SW-1:0]          slot;
  logic                   scan_last;
  logic                   take_cand;
  logic [15:0]            used_inc;
  logic                   out_free;
  logic                   is_load, full, do_write, do_clear;
  dpps_pkg::rec_t         wr_rec;
  logic [SW-1:0]          wr_slot;
  dpps_pkg::outcome_t     res_code;
  logic [CW-1:0]          count_nxt;

  assign slot      = idx_r[SW-1:0];
  assign rd_rec    = recs_r[slot];
  assign scan_last = (idx_r == (SW+1)'(D-1));
  assign out_free  = !ovalid_r || !out_stall;
  assign is_load   = (cur_r.kind == dpps_pkg::KIND_LOAD);
  assign full      = (count_r == CW'(D));

  // scan picks first free slot for load, best valid record for run
  always_comb begin
    if (is_load) take_cand = !vld_r[slot] && !found_r;
    else take_cand = vld_r[slot] &&
                     (!found_r || dpps_pkg::beats(rd_rec, best_rec_r, tie_later_first));
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dpps_pkg::ST_IDLE: if (cmd_valid) state_nxt = dpps_pkg::ST_SCAN;
      dpps_pkg::ST_SCAN: if (scan_last) state_nxt = dpps_pkg::ST_DONE;
      dpps_pkg::ST_DONE: if (out_free) state_nxt = dpps_pkg::ST_IDLE;
      default:           state_nxt = dpps_pkg::ST_IDLE;
    endcase
  end

  assign cmd_take = (state_r == dpps_pkg::ST_IDLE);

  // result of the step, valid in ST_DONE
  always_comb begin
    used_inc = (best_rec_r.used == 16'hFFFF) ? best_rec_r.used : best_rec_r.used + 16'd1;
    wr_rec   = best_rec_r;
    wr_slot  = best_r;
    do_write = 1'b0;
    do_clear = 1'b0;
    res_code = dpps_pkg::OUT_EMPTY;
    count_nxt = count_r;
    if (is_load) begin
      wr_rec = cur_r.rec;
      if (full || !found_r) begin
        res_code = dpps_pkg::OUT_FULL;
      end else begin
        res_code  = dpps_pkg::OUT_LOADED;
        do_write  = 1'b1;
        count_nxt = count_r + CW'(1);
      end
    end else if (found_r) begin
      wr_rec.used = used_inc;
      if (used_inc < best_rec_r.required) begin
        res_code = dpps_pkg::OUT_REQUEUED;
        do_write = 1'b1;
        if (best_rec_r.pri != -8'sd128) wr_rec.pri = best_rec_r.pri - 8'sd1;
      end else begin
        do_clear  = 1'b1;
        count_nxt = count_r - CW'(1);
        res_code  = (used_inc == best_rec_r.required) ? dpps_pkg::OUT_FINISHED
                                                      : dpps_pkg::OUT_OVERRUN;
      end
    end
  end

  wire commit = (state_r == dpps_pkg::ST_DONE) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= dpps_pkg::ST_IDLE;
      vld_r    <= '0;
      count_r  <= '0;
      ovalid_r <= 1'b0;
      found_r  <= 1'b0;
      idx_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (commit) ovalid_r <= 1'b1;
      else if (ovalid_r && !out_stall) ovalid_r <= 1'b0;
      unique case (state_r)
        dpps_pkg::ST_IDLE: begin
          idx_r   <= '0;
          found_r <= 1'b0;
        end
        dpps_pkg::ST_SCAN: begin
          if (take_cand) found_r <= 1'b1;
          if (!scan_last) idx_r <= idx_r + (SW+1)'(1);
        end
        dpps_pkg::ST_DONE: begin
          if (commit) begin
            count_r  <= count_nxt;
            if (do_write) vld_r[wr_slot] <= 1'b1;
            if (do_clear) vld_r[wr_slot] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == dpps_pkg::ST_IDLE && cmd_valid) cur_r <= cmd;
    if (state_r == dpps_pkg::ST_SCAN && take_cand) begin
      best_r     <= slot;
      best_rec_r <= rd_rec;
    end
    if (commit && do_write) recs_r[wr_slot] <= wr_rec;
    if (commit) begin
      out_outcome     <= res_code;
      out_ready_count <= OutCountW'(count_nxt);
      if (!is_load && found_r) begin
        out_run_name     <= best_rec_r.name;
        out_run_priority <= best_rec_r.pri;
        out_run_arrival  <= best_rec_r.arrival;
        out_run_required <= best_rec_r.required;
        out_run_used     <= used_inc;
      end else begin
        out_run_name     <= '0;
        out_run_priority <= '0;
        out_run_arrival  <= '0;
        out_run_required <= '0;
        out_run_used     <= '0;
      end
    end
  end

  assign out_valid = ovalid_r;

endmodule

FILE: rtl/dynamic_priority_process_scheduler_unit.sv
// ----------------------------------------------------------------------------
// dynamic_priority_process_scheduler_unit: priority scheduler with aging
// Ready queue of process records; load inserts, run serves the best record.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | direction
//  in       | in_valid/in_stall, kind + record fields   | item in
//  out      | out_valid/out_stall, outcome + run fields | item out
//  cfg      | cfg_we/cfg_data (tie_later_first)         | register write
//
// In the back end one slot of the ready queue is examined per cycle, then
// the step is committed into the output register. A two-entry queue lets
// the front keep taking items meanwhile. Reset (rst_n low, synchronous)
// empties the ready queue, sets tie-break to later-first. A stalled output
// holds the back end in its final state.
module dynamic_priority_process_scheduler_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_kind,
  input  logic [7:0]          in_proc_name,
  input  logic signed [7:0]   in_proc_priority,
  input  logic [15:0]         in_arrival_time,
  input  logic [15:0]         in_required_time,
  input  logic [15:0]         in_used_time,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          out_outcome,
  output logic [7:0]          out_run_name,
  output logic signed [7:0]   out_run_priority,
  output logic [15:0]         out_run_arrival,
  output logic [15:0]         out_run_required,
  output logic [15:0]         out_run_used,
  output logic [4:0]          out_ready_count
);

  logic           tie_r;
  logic           cmd_valid, cmd_take;
  dpps_pkg::cmd_t cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) tie_r <= 1'b1;
    else if (cfg_we) tie_r <= cfg_data;
  end

  dpps_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_kind, .in_proc_name, .in_proc_priority,
    .in_arrival_time, .in_required_time, .in_used_time,
    .cmd_valid, .cmd, .cmd_take
  );

  dpps_back u_back (
    .clk, .rst_n, .tie_later_first(tie_r), .cmd_valid, .cmd, .cmd_take,
    .out_valid, .out_stall, .out_outcome, .out_run_name, .out_run_priority,
    .out_run_arrival, .out_run_required, .out_run_used, .out_ready_count
  );

`ifndef SYNTH
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_ready_count <= 5'(dpps_pkg::QueueDepth)))
    else $error("ready count above depth");
  a_run_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_outcome == dpps_pkg::OUT_LOADED || out_outcome == dpps_pkg::OUT_FULL
                   || out_outcome == dpps_pkg::OUT_EMPTY)) |-> (out_run_name == '0 &&
                   out_run_used == '0))
    else $error("run fields not cleared");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_outcome)))
    else $error("stalled result changed");
`endif

endmodule

FILE: sim/tb_dynamic_priority_process_scheduler_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dynamic_priority_process_scheduler_unit: scheduler testbench
// Drives load and run items with random gaps and stalls, predicts every
// result with a software copy of the ready queue and compares field by field.
// ----------------------------------------------------------------------------
module tb_dynamic_priority_process_scheduler_unit;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic              cfg_data = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_kind = 1'b0;
  logic [7:0]        in_proc_name = '0;
  logic signed [7:0] in_proc_priority = '0;
  logic [15:0]       in_arrival_time = '0;
  logic [15:0]       in_required_time = '0;
  logic [15:0]       in_used_time = '0;
  logic              out_valid;
  logic              out_stall = 1'b1;
  logic [2:0]        out_outcome;
  logic [7:0]        out_run_name;
  logic signed [7:0] out_run_priority;
  logic [15:0]       out_run_arrival;
  logic [15:0]       out_run_required;
  logic [15:0]       out_run_used;
  logic [4:0]        out_ready_count;

  typedef struct packed {
    logic [2:0]     outcome;
    dpps_pkg::rec_t rec;
    logic [4:0]     count;
  } sched_result_t;

  dpps_pkg::rec_t sched_slots[dpps_pkg::QueueDepth];
  bit             slot_used[dpps_pkg::QueueDepth];
  int             sched_count;
  bit             later_first;
  sched_result_t  pending_results[$];
  int             mismatches = 0;
  int             idle_cycles = 0;
  bit             stall_enable = 1'b0;

  localparam int WatchdogLimit = 20000;

  dynamic_priority_process_scheduler_unit uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  function automatic bit served_first(dpps_pkg::rec_t a, dpps_pkg::rec_t b);
    if (a.pri != b.pri) return a.pri > b.pri;
    if (later_first) return a.arrival > b.arrival;
    return a.arrival < b.arrival;
  endfunction

  // software copy of the ready queue; returns the result this item causes
  function automatic sched_result_t predict_step(logic kind, dpps_pkg::rec_t rec);
    sched_result_t res;
    int best;
    int i;
    res = '0;
    if (kind == dpps_pkg::KIND_LOAD) begin
      res.outcome = dpps_pkg::OUT_FULL;
      if (sched_count < dpps_pkg::QueueDepth) begin
        for (i = 0; i < dpps_pkg::QueueDepth; i++)
          if (!slot_used[i]) break;
        sched_slots[i] = rec;
        slot_used[i] = 1'b1;
        sched_count++;
        res.outcome = dpps_pkg::OUT_LOADED;
      end
    end else begin
      best = -1;
      for (i = 0; i < dpps_pkg::QueueDepth; i++)
        if (slot_used[i] && (best < 0 || served_first(sched_slots[i], sched_slots[best])))
          best = i;
      if (best < 0) begin
        res.outcome = dpps_pkg::OUT_EMPTY;
      end else begin
        res.rec = sched_slots[best];
        if (sched_slots[best].used != 16'hFFFF) sched_slots[best].used++;
        res.rec.used = sched_slots[best].used;
        if (sched_slots[best].used < sched_slots[best].required) begin
          if (sched_slots[best].pri != -8'sd128) sched_slots[best].pri--;
          res.outcome = dpps_pkg::OUT_REQUEUED;
        end else begin
          slot_used[best] = 1'b0;
          sched_count--;
          res.outcome = (sched_slots[best].used == sched_slots[best].required) ?
                        dpps_pkg::OUT_FINISHED : dpps_pkg::OUT_OVERRUN;
        end
      end
    end
    res.count = sched_count[4:0];
    return res;
  endfunction

  // in_valid stays up after an accepted item until a gap or a drain drops it
  task automatic send_item(logic kind, dpps_pkg::rec_t rec);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_proc_name <= rec.name;
    in_proc_priority <= rec.pri;
    in_arrival_time <= rec.arrival;
    in_required_time <= rec.required;
    in_used_time <= rec.used;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_step(kind, rec));
  endtask

  task automatic load_rec(logic [7:0] nm, logic signed [7:0] pr, logic [15:0] arr,
                          logic [15:0] req, logic [15:0] usd);
    dpps_pkg::rec_t r;
    r.name = nm; r.pri = pr; r.arrival = arr; r.required = req; r.used = usd;
    send_item(dpps_pkg::KIND_LOAD, r);
  endtask

  task automatic run_slice();
    send_item(dpps_pkg::KIND_RUN, dpps_pkg::rec_t'({$urandom, $urandom}));
  endtask

  task automatic drain_and_wait();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3 * dpps_pkg::QueueDepth + 10) @(posedge clk);
  endtask

  task automatic set_tie_order(bit v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    later_first = v;
  endtask

  task automatic empty_queue();
    while (sched_count > 0) run_slice();
  endtask

  task automatic test_directed();
    run_slice();                                    // empty queue
    load_rec(8'hFF, 8'sh7F, 16'hFFFF, 16'hFFFF, 16'hFFFE);
    load_rec(8'h00, -8'sd128, 16'h0000, 16'h0002, 16'h0000);
    load_rec(8'hA5, 8'sh7F, 16'h0010, 16'h0000, 16'hFFFF); // saturate, overrun
    load_rec(8'h5A, 8'sh7F, 16'h0010, 16'h0003, 16'h0003); // tie, same arrival
    load_rec(8'h11, 8'sh10, 16'h0001, 16'h0001, 16'h0005);
    repeat (8) run_slice();
    empty_queue();
    run_slice();
  endtask

  task automatic test_full_queue();
    int i;
    for (i = 0; i < dpps_pkg::QueueDepth + 2; i++)
      load_rec(8'(i), 8'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
               16'($urandom_range(1, 4)), 16'd0);
    empty_queue();
  endtask

  task automatic test_random(int n);
    int i;
    dpps_pkg::rec_t r;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 45 || sched_count == 0 && $urandom_range(0, 9) != 0) begin
        r = dpps_pkg::rec_t'({$urandom, $urandom});
        if ($urandom_range(0, 3) != 0) begin
          r.pri = 8'(int'($urandom_range(0, 7)) - 4);
          r.arrival = 16'($urandom_range(0, 5));
          r.required = 16'($urandom_range(0, 6));
          r.used = 16'($urandom_range(0, 5));
        end
        send_item(dpps_pkg::KIND_LOAD, r);
      end else begin
        run_slice();
      end
    end
  endtask

  // result checker
  always @(posedge clk) begin
    sched_result_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: outcome %0d", out_outcome);
      end else begin
        exp_res = pending_results.pop_front();
        if (out_outcome !== exp_res.outcome || out_run_name !== exp_res.rec.name ||
            out_run_priority !== exp_res.rec.pri ||
            out_run_arrival !== exp_res.rec.arrival ||
            out_run_required !== exp_res.rec.required ||
            out_run_used !== exp_res.rec.used || out_ready_count !== exp_res.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d %h %0d %h %h %h %0d got %0d %h %0d %h %h %h %0d",
                     exp_res.outcome, exp_res.rec.name, exp_res.rec.pri,
                     exp_res.rec.arrival, exp_res.rec.required, exp_res.rec.used,
                     exp_res.count, out_outcome, out_run_name, out_run_priority,
                     out_run_arrival, out_run_required, out_run_used, out_ready_count);
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (!stall_enable) out_stall <= 1'b0;
    else if ($urandom_range(0, 49) == 0) out_stall <= 1'b1;
    else if (out_stall) out_stall <= ($urandom_range(0, 3) != 0);
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    later_first = 1'b1;
    sched_count = 0;
    foreach (slot_used[i]) slot_used[i] = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    drain_and_wait();
    set_tie_order(1'b0);
    test_directed();
    stall_enable = 1'b1;
    test_full_queue();
    test_random(300);
    drain_and_wait();           // sender holds off until all results are in
    set_tie_order(1'b1);
    test_random(300);
    drain_and_wait();
    set_tie_order(1'b0);
    stall_enable = 1'b0;
    test_random(150);
    drain_and_wait();
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: files.f
rtl/dpps_pkg.sv
rtl/dpps_front.sv
rtl/dpps_back.sv
rtl/dynamic_priority_process_scheduler_unit.sv
sim/tb_dynamic_priority_process_scheduler_unit.sv
